>>> rtl/bbf_pkg.sv
package bbf_pkg;

  // field widths of a queued descriptor and of the byte accounting
  localparam int TAG_W   = 32;
  localparam int SIZE_W  = 16;
  localparam int TIME_W  = 32;
  localparam int BYTES_W = 24;
  localparam int LIM_W   = 7;
  localparam int OUT_CNT_W = 7;

  // stream word widths
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 120;

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_LIMIT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYTE_LIMIT  = 8'd1;

  localparam logic [LIM_W-1:0]   DEPTH_LIMIT_RST = 7'd64;
  localparam logic [BYTES_W-1:0] BYTE_LIMIT_RST  = 24'd1048576;

  // operation codes carried in the input word
  typedef enum logic [1:0] {
    FUNC_PUT  = 2'd0,
    FUNC_GET  = 2'd1,
    FUNC_DROP = 2'd2
  } func_e;

  // shared adder mode
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  // one stored descriptor
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [SIZE_W-1:0] size;
    logic [TIME_W-1:0] arr_time;
  } entry_t;

endpackage

>>> rtl/byte_budget_fifo_drop_oldest.sv
// Descriptor queue with an entry limit and a byte budget, dropping the oldest.
// Input stream (s_axis): one word per operation: put, get head or drop head.
// Output stream (m_axis): exactly one result word per operation, in order.
// Config channel (cfg_*): register 0 depth_limit, register 1 byte_limit; always
// ready. The user must see that it is written only while the queue is idle;
// the block itself does not enforce this.
// Each operation passes the states read, a registered head read of the
// descriptor memory, and eval; get and drop then pass pop, and each entry a
// put has to drop adds a pop and a new read and eval. Eval and pop each make
// one pass through the shared 25 bit byte adder.
// s_axis_tready is high only while no operation is in flight; one operation
// is worked on at a time, so a new word is taken only once the previous one
// has written its result.
// The result register decouples the sides: the next word is accepted while a
// result waits; a stalled receiver holds the result and the sequencer then
// waits before writing the following one.
// Reset empties the queue (head, count, byte total cleared) and restores the
// limits to 64 entries and 1048576 bytes; descriptor memory is not cleared.
module byte_budget_fifo_drop_oldest #(
  parameter int DEPTH = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // func, item_tag, item_size, arrival_time (lowest bit first), zero pad
  input  logic [bbf_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // ok, drop_count, out_tag, out_size, out_time, queue_length, queue_bytes, pad
  output logic [bbf_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bbf_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bbf_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > bbf_pkg::LIM_W) ? CW : bbf_pkg::LIM_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RD   = 4'b0010,
    ST_EVAL = 4'b0100,
    ST_POP  = 4'b1000
  } state_e;

  state_e                          state_q, state_d;
  bbf_pkg::func_e                  func_q, func_d;
  logic [bbf_pkg::TAG_W-1:0]       tag_q, tag_d;
  logic [bbf_pkg::SIZE_W-1:0]      size_q, size_d;
  logic [bbf_pkg::TIME_W-1:0]      time_q, time_d;
  logic [IW-1:0]                   head_q, head_d;
  logic [CW-1:0]                   count_q, count_d;
  logic [bbf_pkg::BYTES_W-1:0]     total_q, total_d;
  logic [CW-1:0]                   drops_q, drops_d;
  logic [bbf_pkg::LIM_W-1:0]       depth_lim_q;
  logic [bbf_pkg::BYTES_W-1:0]     byte_lim_q;
  logic                            m_valid_q, m_valid_d;

  // result register
  logic                            res_ok_q, res_ok_d;
  logic [bbf_pkg::OUT_CNT_W-1:0]   res_drops_q, res_drops_d;
  logic [bbf_pkg::TAG_W-1:0]       res_tag_q, res_tag_d;
  logic [bbf_pkg::SIZE_W-1:0]      res_size_q, res_size_d;
  logic [bbf_pkg::TIME_W-1:0]      res_time_q, res_time_d;
  logic [bbf_pkg::OUT_CNT_W-1:0]   res_len_q, res_len_d;
  logic [bbf_pkg::BYTES_W-1:0]     res_bytes_q, res_bytes_d;

  logic                            in_fire;
  logic                            out_free;
  logic [LW-1:0]                   dl_ext;
  logic [LW-1:0]                   eff_dl;
  logic                            at_depth;
  logic                            too_big;
  logic [IW-1:0]                   head_inc;
  logic [IW:0]                     slot_sum;
  logic [IW-1:0]                   slot;
  logic                            wr_en;
  bbf_pkg::entry_t                 wr_data;
  bbf_pkg::entry_t                 rd_data;
  bbf_pkg::alu_op_e                alu_op;
  logic [bbf_pkg::SIZE_W-1:0]      alu_operand;
  logic [bbf_pkg::BYTES_W:0]       alu_result;
  logic                            alu_over;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // effective depth limit, clamped to 1..DEPTH
  assign dl_ext   = LW'(depth_lim_q);
  assign eff_dl   = (dl_ext == '0) ? LW'(1) :
                    ((dl_ext > LW'(DEPTH)) ? LW'(DEPTH) : dl_ext);
  assign at_depth = LW'(count_q) >= eff_dl;
  assign too_big  = {8'd0, size_q} > byte_lim_q;

  // ring pointer arithmetic
  assign head_inc = (head_q == IW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign slot_sum = {1'b0, head_q} + (IW + 1)'(count_q);
  assign slot     = (slot_sum >= (IW + 1)'(DEPTH)) ?
                    IW'(slot_sum - (IW + 1)'(DEPTH)) : slot_sum[IW-1:0];

  // shared adder: budget check in eval, head removal in pop
  assign alu_op      = (state_q == ST_POP) ? bbf_pkg::ALU_SUB : bbf_pkg::ALU_ADD;
  assign alu_operand = (state_q == ST_POP) ? rd_data.size : size_q;

  bbf_unit u_unit (
    .op_i      (alu_op),
    .total_i   (total_q),
    .operand_i (alu_operand),
    .limit_i   (byte_lim_q),
    .result_o  (alu_result),
    .over_o    (alu_over)
  );

  assign wr_data.tag      = tag_q;
  assign wr_data.size     = size_q;
  assign wr_data.arr_time = time_q;

  bbf_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (slot),
    .wr_data_i (wr_data),
    .rd_en_i   (state_q == ST_RD),
    .rd_addr_i (head_q),
    .rd_data_o (rd_data)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    tag_d       = tag_q;
    size_d      = size_q;
    time_d      = time_q;
    head_d      = head_q;
    count_d     = count_q;
    total_d     = total_q;
    drops_d     = drops_q;
    wr_en       = 1'b0;
    m_valid_d   = m_valid_q && !m_axis_tready;
    res_ok_d    = res_ok_q;
    res_drops_d = res_drops_q;
    res_tag_d   = res_tag_q;
    res_size_d  = res_size_q;
    res_time_d  = res_time_q;
    res_len_d   = res_len_q;
    res_bytes_d = res_bytes_q;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          func_d  = bbf_pkg::func_e'(s_axis_tdata[1:0]);
          tag_d   = s_axis_tdata[33:2];
          size_d  = s_axis_tdata[49:34];
          time_d  = s_axis_tdata[81:50];
          drops_d = '0;
          state_d = ST_RD;
        end
      end

      ST_RD: begin
        state_d = ST_EVAL;
      end

      ST_EVAL: begin
        // default answer: failure with current occupancy, only once the slot is free
        if (out_free) begin
          res_ok_d    = 1'b0;
          res_drops_d = '0;
          res_tag_d   = '0;
          res_size_d  = '0;
          res_time_d  = '0;
          res_len_d   = bbf_pkg::OUT_CNT_W'(count_q);
          res_bytes_d = total_q;
        end
        case (func_q)
          bbf_pkg::FUNC_PUT: begin
            if (too_big) begin
              if (out_free) begin
                m_valid_d = 1'b1;
                state_d   = ST_IDLE;
              end
            end else if ((count_q != '0) && (at_depth || alu_over)) begin
              state_d = ST_POP;
            end else if (out_free) begin
              // append at the tail
              wr_en       = 1'b1;
              count_d     = count_q + 1'b1;
              total_d     = alu_result[bbf_pkg::BYTES_W-1:0];
              res_ok_d    = 1'b1;
              res_drops_d = bbf_pkg::OUT_CNT_W'(drops_q);
              res_len_d   = bbf_pkg::OUT_CNT_W'(count_d);
              res_bytes_d = total_d;
              m_valid_d   = 1'b1;
              state_d     = ST_IDLE;
            end
          end
          bbf_pkg::FUNC_GET, bbf_pkg::FUNC_DROP: begin
            if (count_q != '0) begin
              state_d = ST_POP;
            end else if (out_free) begin
              m_valid_d = 1'b1;
              state_d   = ST_IDLE;
            end
          end
          default: begin
            if (out_free) begin
              m_valid_d = 1'b1;
              state_d   = ST_IDLE;
            end
          end
        endcase
      end

      ST_POP: begin
        if (func_q == bbf_pkg::FUNC_PUT) begin
          // drop the oldest, then look at the new head
          head_d  = head_inc;
          count_d = count_q - 1'b1;
          total_d = alu_result[bbf_pkg::BYTES_W-1:0];
          drops_d = drops_q + 1'b1;
          state_d = ST_RD;
        end else if (out_free) begin
          head_d      = head_inc;
          count_d     = count_q - 1'b1;
          total_d     = alu_result[bbf_pkg::BYTES_W-1:0];
          res_ok_d    = 1'b1;
          res_drops_d = '0;
          res_tag_d   = (func_q == bbf_pkg::FUNC_GET) ? rd_data.tag : '0;
          res_size_d  = (func_q == bbf_pkg::FUNC_GET) ? rd_data.size : '0;
          res_time_d  = (func_q == bbf_pkg::FUNC_GET) ? rd_data.arr_time : '0;
          res_len_d   = bbf_pkg::OUT_CNT_W'(count_d);
          res_bytes_d = total_d;
          m_valid_d   = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      head_q    <= '0;
      count_q   <= '0;
      total_q   <= '0;
      drops_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      count_q   <= count_d;
      total_q   <= total_d;
      drops_q   <= drops_d;
      m_valid_q <= m_valid_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_lim_q <= bbf_pkg::DEPTH_LIMIT_RST;
      byte_lim_q  <= bbf_pkg::BYTE_LIMIT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bbf_pkg::REG_DEPTH_LIMIT: depth_lim_q <= cfg_data_i[bbf_pkg::LIM_W-1:0];
        bbf_pkg::REG_BYTE_LIMIT:  byte_lim_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // operation and result payload
  always_ff @(posedge clk_i) begin
    func_q      <= func_d;
    tag_q       <= tag_d;
    size_q      <= size_d;
    time_q      <= time_d;
    res_ok_q    <= res_ok_d;
    res_drops_q <= res_drops_d;
    res_tag_q   <= res_tag_d;
    res_size_q  <= res_size_d;
    res_time_q  <= res_time_d;
    res_len_q   <= res_len_d;
    res_bytes_q <= res_bytes_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, res_bytes_q, res_len_q, res_time_q, res_size_q,
                          res_tag_q, res_drops_q, res_ok_q};

endmodule

>>> rtl/bbf_store.sv
module bbf_store #(
  parameter int DEPTH = 64
) (
  input  logic                            clk_i,
  input  logic                            wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]        wr_addr_i,
  input  bbf_pkg::entry_t                 wr_data_i,
  input  logic                            rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]        rd_addr_i,
  output bbf_pkg::entry_t                 rd_data_o
);

  bbf_pkg::entry_t mem [DEPTH];
  bbf_pkg::entry_t rd_data_q;

  // single write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/bbf_unit.sv
module bbf_unit (
  input  bbf_pkg::alu_op_e                 op_i,
  input  logic [bbf_pkg::BYTES_W-1:0]      total_i,
  input  logic [bbf_pkg::SIZE_W-1:0]       operand_i,
  input  logic [bbf_pkg::BYTES_W-1:0]      limit_i,
  output logic [bbf_pkg::BYTES_W:0]        result_o,
  output logic                             over_o
);

  logic [bbf_pkg::BYTES_W:0] total_ext;
  logic [bbf_pkg::BYTES_W:0] operand_ext;

  assign total_ext   = {1'b0, total_i};
  assign operand_ext = (bbf_pkg::BYTES_W + 1)'(operand_i);

  // byte total plus or minus one descriptor size
  always_comb begin
    case (op_i)
      bbf_pkg::ALU_ADD: result_o = total_ext + operand_ext;
      bbf_pkg::ALU_SUB: result_o = total_ext - operand_ext;
      default:          result_o = total_ext;
    endcase
  end

  // budget check on the new total
  assign over_o = result_o > {1'b0, limit_i};

endmodule

>>> rtl/bbf_checker.sv
module bbf_checker #(
  parameter int DEPTH = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  input  logic                               s_axis_tready,
  input  logic [bbf_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                               m_axis_tvalid,
  input  logic                               m_axis_tready
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // one operation in flight: input closes right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an operation is in flight");

  // a failed operation reports no drops and no entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> (m_axis_tdata[87:1] == '0))
    else $error("failed operation carries drop or entry fields");

  // occupancy never exceeds the storage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[94:88] <= DEPTH))
    else $error("queue length above storage depth");

endmodule

bind byte_budget_fifo_drop_oldest bbf_checker #(
  .DEPTH (DEPTH)
) u_bbf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

>>> tb/byte_budget_fifo_drop_oldest_tb.sv
`timescale 1ns / 1ps

module byte_budget_fifo_drop_oldest_tb;
  import bbf_pkg::*;

  localparam int QDEPTH = 64;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 183;
  localparam int NUM_PHASES = 7;

  // unused operation code, answered with ok=0 and nothing changed
  localparam logic [1:0] FUNC_NOP = 2'd3;

  // input word, lowest field last
  typedef struct packed {
    logic [5:0]        pad;
    logic [TIME_W-1:0] arr_time;
    logic [SIZE_W-1:0] size;
    logic [TAG_W-1:0]  tag;
    logic [1:0]        func;
  } op_word_t;

  // result word, lowest field last
  typedef struct packed {
    logic                 pad;
    logic [BYTES_W-1:0]   bytes;
    logic [OUT_CNT_W-1:0] len;
    logic [TIME_W-1:0]    arr_time;
    logic [SIZE_W-1:0]    size;
    logic [TAG_W-1:0]     tag;
    logic [OUT_CNT_W-1:0] drops;
    logic                 ok;
  } reply_word_t;

  // predicts the reply to every accepted word and checks replies in order
  class queue_scoreboard;
    logic [TAG_W-1:0]  tag_mem[QDEPTH];
    logic [SIZE_W-1:0] size_mem[QDEPTH];
    logic [TIME_W-1:0] time_mem[QDEPTH];
    int unsigned head;
    int unsigned count;
    int unsigned total;
    int unsigned depth_lim;
    int unsigned byte_lim;
    reply_word_t pending_replies[$];
    int errors;

    function new();
      head = 0;
      count = 0;
      total = 0;
      depth_lim = 32'(DEPTH_LIMIT_RST);
      byte_lim = 32'(BYTE_LIMIT_RST);
      errors = 0;
    endfunction

    function int pending();
      return pending_replies.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_DEPTH_LIMIT) depth_lim = 32'(val[6:0]);
      else if (idx == REG_BYTE_LIMIT) byte_lim = 32'(val);
    endfunction

    function void pop_head();
      total = total - size_mem[head];
      head = (head + 1) % QDEPTH;
      count = count - 1;
    endfunction

    // note an accepted word and queue its expected reply
    function void note_word(op_word_t w);
      reply_word_t r;
      int unsigned lim;
      int unsigned slot;
      r = '0;
      case (w.func)
        FUNC_PUT: begin
          if (w.size <= byte_lim) begin
            lim = (depth_lim < 1) ? 1 : (depth_lim > QDEPTH) ? QDEPTH : depth_lim;
            while (count > 0 && (count >= lim || total + w.size > byte_lim)) begin
              pop_head();
              r.drops = r.drops + 1'b1;
            end
            slot = (head + count) % QDEPTH;
            tag_mem[slot] = w.tag;
            size_mem[slot] = w.size;
            time_mem[slot] = w.arr_time;
            count = count + 1;
            total = total + w.size;
            r.ok = 1'b1;
          end
        end
        FUNC_GET, FUNC_DROP: begin
          if (count > 0) begin
            if (w.func == FUNC_GET) begin
              r.tag = tag_mem[head];
              r.size = size_mem[head];
              r.arr_time = time_mem[head];
            end
            pop_head();
            r.ok = 1'b1;
          end
        end
        default: ;
      endcase
      r.len = OUT_CNT_W'(count);
      r.bytes = BYTES_W'(total);
      pending_replies.push_back(r);
    endfunction

    // compare an accepted reply with the oldest expectation
    function void check_result(reply_word_t got);
      reply_word_t want;
      if (pending_replies.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected reply word %h", got);
        return;
      end
      want = pending_replies.pop_front();
      if (got.ok !== want.ok || got.drops !== want.drops || got.tag !== want.tag ||
          got.size !== want.size || got.arr_time !== want.arr_time ||
          got.len !== want.len || got.bytes !== want.bytes) begin
        errors++;
        if (errors <= 10) begin
          $write("mismatch at %0t: expected ok=%0d drops=%0d tag=%h size=%h",
                 $realtime, want.ok, want.drops, want.tag, want.size);
          $display(" time=%h len=%0d bytes=%0d", want.arr_time, want.len, want.bytes);
          $write("                   actual ok=%0d drops=%0d tag=%h size=%h",
                 got.ok, got.drops, got.tag, got.size);
          $display(" time=%h len=%0d bytes=%0d", got.arr_time, got.len, got.bytes);
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  op_word_t s_tdata;
  logic s_tvalid;
  logic s_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  queue_scoreboard sb;
  int send_idle_pct;
  int stall_pct;
  logic hold_on = 1'b0;
  int cycle_cnt = 0;
  event hold_kick;

  byte_budget_fifo_drop_oldest dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_tdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // receiver ready with random stalls and the long hold-off
  always @(posedge clk_i) begin
    m_tready <= !hold_on && ($urandom_range(99) >= stall_pct);
  end

  // long receiver hold-off, counted here
  always begin
    @(hold_kick);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  // reply checking
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("byte_budget_fifo_drop_oldest_tb failed");
      $finish;
    end
  end

  // offer one word after a random gap and wait until it is taken
  task automatic send_word(input op_word_t w);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= w;
    do @(posedge clk_i); while (!s_tready);
    sb.note_word(w);
  endtask

  task automatic do_op(input logic [1:0] f, input logic [TAG_W-1:0] tag,
                       input logic [SIZE_W-1:0] size, input logic [TIME_W-1:0] tim);
    op_word_t w;
    w = '0;
    w.func = f;
    w.tag = tag;
    w.size = size;
    w.arr_time = tim;
    send_word(w);
  endtask

  // stop offering and wait for every outstanding reply
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  task automatic set_limits(input int depth, input int bytes);
    settle();
    write_reg(REG_DEPTH_LIMIT, CFG_DATA_W'(depth));
    write_reg(REG_BYTE_LIMIT, CFG_DATA_W'(bytes));
    cfg_valid <= 1'b0;
  endtask

  // random operation, puts weighted to fill the queue
  task automatic random_op(input int put_pct, input int size_cap);
    int r;
    int k;
    logic [1:0] f;
    logic [SIZE_W-1:0] sz;
    r = $urandom_range(99);
    if (r < put_pct) f = FUNC_PUT;
    else if (r < put_pct + (100 - put_pct) * 6 / 10) f = FUNC_GET;
    else if (r < 96) f = FUNC_DROP;
    else f = FUNC_NOP;
    k = $urandom_range(9);
    if (k == 0) sz = '0;
    else if (k == 1) sz = '1;
    else if (k <= 6) sz = SIZE_W'($urandom_range(size_cap));
    else sz = SIZE_W'($urandom);
    do_op(f, $urandom, sz, $urandom);
  endtask

  int phase_depth[NUM_PHASES] = '{64, 4, 127, 0, 16, 2, 64};
  int phase_bytes[NUM_PHASES] = '{24'hFFFFFF, 200000, 1048576, 65535, 0, 300, 1048576};
  int phase_cap[NUM_PHASES]   = '{65535, 60000, 65535, 40000, 1, 200, 30000};
  int phase_put[NUM_PHASES]   = '{72, 55, 70, 55, 60, 55, 62};

  initial begin
    sb = new();
    rst_ni = 1'b0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // empty queue, unused code, field extremes, plain get and drop
    do_op(FUNC_GET, $urandom, SIZE_W'($urandom), $urandom);
    do_op(FUNC_DROP, $urandom, SIZE_W'($urandom), $urandom);
    do_op(FUNC_NOP, '1, '1, '1);
    do_op(FUNC_PUT, '0, '0, '0);
    do_op(FUNC_PUT, '1, '1, '1);
    do_op(FUNC_PUT, 32'hAAAA5555, 16'h5555, 32'h5555AAAA);
    do_op(FUNC_GET, '0, '0, '0);
    do_op(FUNC_GET, $urandom, SIZE_W'($urandom), $urandom);
    do_op(FUNC_DROP, $urandom, SIZE_W'($urandom), $urandom);
    do_op(FUNC_GET, $urandom, SIZE_W'($urandom), $urandom);

    // one entry deep, small budget: depth drops and oversize reject
    set_limits(1, 100);
    do_op(FUNC_PUT, $urandom, 16'd50, $urandom);
    do_op(FUNC_PUT, $urandom, 16'd60, $urandom);
    do_op(FUNC_PUT, $urandom, 16'd101, $urandom);
    do_op(FUNC_PUT, $urandom, 16'd100, $urandom);
    do_op(FUNC_GET, $urandom, SIZE_W'($urandom), $urandom);
    do_op(FUNC_PUT, $urandom, 16'd90, $urandom);

    // budget lowered below the bytes held
    set_limits(1, 30);
    do_op(FUNC_PUT, $urandom, 16'd10, $urandom);

    // depth limit of zero acts as one
    set_limits(0, 24'hFFFFFF);
    do_op(FUNC_PUT, $urandom, 16'd20, $urandom);

    // depth limit above range, zero budget
    set_limits(127, 0);
    do_op(FUNC_PUT, $urandom, 16'd0, $urandom);
    do_op(FUNC_PUT, $urandom, 16'd1, $urandom);
    do_op(FUNC_DROP, $urandom, SIZE_W'($urandom), $urandom);
    do_op(FUNC_DROP, $urandom, SIZE_W'($urandom), $urandom);

    // random phases over limit settings and idling modes
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_limits(phase_depth[p], phase_bytes[p]);
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 74;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 74;
        end
        default: begin
          send_idle_pct = 25;
          stall_pct = 25;
        end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 0 && i == 60) -> hold_kick;
        random_op(phase_put[p], phase_cap[p]);
      end
    end

    settle();
    repeat (250) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $display("%0d expected replies never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("byte_budget_fifo_drop_oldest_tb passed");
    end else begin
      $display("byte_budget_fifo_drop_oldest_tb failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/bbf_pkg.sv
rtl/bbf_store.sv
rtl/bbf_unit.sv
rtl/byte_budget_fifo_drop_oldest.sv
rtl/bbf_checker.sv
tb/byte_budget_fifo_drop_oldest_tb.sv
